@@ rtl/core/tlvp_pkg.sv @@
// Package for the TLV message parser: payload structs, event and error codes,
// phase encoding and the default result queue depth. No dependencies.
package tlvp_pkg;

  // Default depth of the result queue (must be at least 2).
  localparam int TLVP_FIFO_DEPTH = 4;

  // Varint limits and the largest legal message length.
  localparam logic [7:0]  SHORT_MAX  = 8'd127;
  localparam logic [7:0]  PREFIX_ONE = 8'h81;
  localparam logic [7:0]  PREFIX_TWO = 8'h82;
  localparam logic [17:0] MSG_MAX    = 18'h0FFFF;

  // Event codes of a result item.
  localparam logic [2:0] EV_HEADER    = 3'd0;
  localparam logic [2:0] EV_ARG_START = 3'd1;
  localparam logic [2:0] EV_VALUE     = 3'd2;
  localparam logic [2:0] EV_MSG_END   = 3'd3;
  localparam logic [2:0] EV_ERROR     = 3'd4;

  // Error codes carried with an error event.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_PREFIX    = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

  // Parser phases, one-hot.
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_ID     = 4'b0010,
    PH_LEN    = 4'b0100,
    PH_VALUE  = 4'b1000
  } phase_t;

  // One input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] header_length;
    logic [15:0] header_protocol;
    logic [15:0] arg_id;
    logic [15:0] arg_length;
    logic [7:0]  value_byte;
    logic        last_of_arg;
    logic [1:0]  error_code;
    logic        last_result;
  } out_item_t;

  // Results produced by one accepted byte, handed to the result queue.
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  first;
    out_item_t  second;
  } tlvp_push_t;

endpackage

@@ rtl/core/tlv_message_parser_top.sv @@
// Top level of the TLV message parser: byte parser feeding a result queue.
// Depends on tlvp_pkg, tlvp_parser and tlvp_out_fifo.
//
//  Channel | Ports                           | Payload
//  input   | in_valid, in_ready, in_data     | in_item_t: data_byte, end_of_stream
//  result  | out_valid, out_ready, out_data  | out_item_t: event and fields
//
// One byte is parsed in the cycle of its transfer; its zero to two results
// enter the result queue at that edge and are offered from the next cycle.
// Sustained rate is one byte per cycle while results drain one per cycle;
// the single-result output port sets the limit when bytes produce two results.
// in_ready is high while the queue has room for two results.
// Reset (rst_n low, synchronous) clears the parser state and empties the queue.
module tlv_message_parser_top import tlvp_pkg::*; #(
  parameter int DEPTH = TLVP_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  tlvp_push_t push;
  logic       accept;

  // Input transfer.
  assign accept = in_valid && in_ready;

  tlvp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .push   (push)
  );

  tlvp_out_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/tlvp_parser.sv @@
// Byte parser state and the per-byte step logic of the TLV message parser.
// Depends on tlvp_pkg.
module tlvp_parser import tlvp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  in_item_t   item,
  output tlvp_push_t push
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  bp_r, bp_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] cid_r, cid_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] hl_r, hl_nxt;
  logic [15:0] hp_r, hp_nxt;
  logic [16:0] rl_r, rl_nxt;
  logic        errl_r, errl_nxt;

  logic        done;
  logic [15:0] v;
  logic [1:0]  err;
  logic [17:0] total;
  logic        prim_v, sec_v;
  out_item_t   prim, sec;
  logic [7:0]  b;

  // Encoded size of a varint value: one, two or three bytes.
  function automatic logic [1:0] enc_size(input logic [15:0] val);
    if (val <= 16'(SHORT_MAX)) begin
      enc_size = 2'd1;
    end else if (val <= 16'd255) begin
      enc_size = 2'd2;
    end else begin
      enc_size = 2'd3;
    end
  endfunction

  function automatic out_item_t mk(input logic [2:0] ev, input logic [15:0] hl,
                                   input logic [15:0] hp, input logic [15:0] id,
                                   input logic [15:0] len, input logic [7:0] vb,
                                   input logic last, input logic [1:0] ec);
    out_item_t o;
    o.event_res       = ev;
    o.header_length   = hl;
    o.header_protocol = hp;
    o.arg_id          = id;
    o.arg_length      = len;
    o.value_byte      = vb;
    o.last_of_arg     = last;
    o.error_code      = ec;
    o.last_result     = 1'b0;
    return o;
  endfunction

  // One step of the parser for the byte being transferred.
  always_comb begin
    b         = item.data_byte;
    phase_nxt = phase_r;
    bp_nxt    = bp_r;
    acc_nxt   = acc_r;
    cid_nxt   = cid_r;
    rem_nxt   = rem_r;
    hl_nxt    = hl_r;
    hp_nxt    = hp_r;
    rl_nxt    = rl_r;
    errl_nxt  = errl_r;
    done      = 1'b0;
    v         = '0;
    err       = ERR_NONE;
    total     = '0;
    prim_v    = 1'b0;
    sec_v     = 1'b0;
    prim      = '0;
    sec       = '0;

    if (!errl_r) begin
      case (phase_r)
        PH_HEADER: begin
          if (bp_r < 2'd2) begin
            hl_nxt = {hl_r[7:0], b};
          end else begin
            hp_nxt = {hp_r[7:0], b};
          end
          if (bp_r == 2'd3) begin
            phase_nxt = PH_ID;
            bp_nxt    = 2'd0;
            prim_v    = 1'b1;
            prim      = mk(EV_HEADER, hl_nxt, hp_nxt, '0, '0, '0, 1'b0, ERR_NONE);
          end else begin
            bp_nxt = bp_r + 2'd1;
          end
        end
        PH_ID, PH_LEN: begin
          if (bp_r == 2'd0) begin
            if (b <= SHORT_MAX) begin
              done = 1'b1;
              v    = {8'd0, b};
            end else if (b == PREFIX_ONE) begin
              bp_nxt  = 2'd1;
              acc_nxt = '0;
            end else if (b == PREFIX_TWO) begin
              bp_nxt  = 2'd2;
              acc_nxt = '0;
            end else begin
              err = ERR_PREFIX;
            end
          end else begin
            acc_nxt = {acc_r[7:0], b};
            bp_nxt  = bp_r - 2'd1;
            if (bp_nxt == 2'd0) begin
              done = 1'b1;
              v    = acc_nxt;
            end
          end
          if (done && phase_r == PH_ID) begin
            cid_nxt   = v;
            phase_nxt = PH_LEN;
          end else if (done) begin
            total = {1'b0, rl_r} + 18'(enc_size(cid_r)) + 18'(enc_size(v)) + {2'd0, v};
            if (total > MSG_MAX) begin
              err = ERR_OVERFLOW;
            end else begin
              rl_nxt = total[16:0];
              prim_v = 1'b1;
              prim   = mk(EV_ARG_START, hl_r, hp_r, cid_r, v, '0, 1'b0, ERR_NONE);
              rem_nxt = v;
              if (v == 16'd0) begin
                phase_nxt = PH_ID;
              end else begin
                phase_nxt = PH_VALUE;
              end
            end
          end
        end
        PH_VALUE: begin
          prim_v  = 1'b1;
          prim    = mk(EV_VALUE, hl_r, hp_r, cid_r, '0, b, rem_r == 16'd1, ERR_NONE);
          rem_nxt = rem_r - 16'd1;
          if (rem_nxt == 16'd0) begin
            phase_nxt = PH_ID;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase

      // A varint error replaces any other result of this byte.
      if (err != ERR_NONE) begin
        prim_v   = 1'b1;
        prim     = mk(EV_ERROR, hl_nxt, hp_nxt, '0, '0, '0, 1'b0, err);
        errl_nxt = 1'b1;
      end

      // End of stream closes the message, cleanly or as truncated.
      if (item.end_of_stream && !errl_nxt) begin
        sec_v = 1'b1;
        if (phase_nxt == PH_ID && bp_nxt == 2'd0) begin
          sec = mk(EV_MSG_END, hl_nxt, hp_nxt, '0, '0, '0, 1'b0, ERR_NONE);
        end else begin
          sec = mk(EV_ERROR, hl_nxt, hp_nxt, '0, '0, '0, 1'b0, ERR_TRUNCATED);
        end
      end
    end

    // Every end of stream restarts the parser.
    if (item.end_of_stream) begin
      phase_nxt = PH_HEADER;
      bp_nxt    = '0;
      acc_nxt   = '0;
      cid_nxt   = '0;
      rem_nxt   = '0;
      hl_nxt    = '0;
      hp_nxt    = '0;
      rl_nxt    = 17'd2;
      errl_nxt  = 1'b0;
    end
  end

  // Pack the results into queue slots and flag the final one.
  always_comb begin
    push = '0;
    if (accept) begin
      if (prim_v) begin
        push.first  = prim;
        push.second = sec;
        push.cnt    = sec_v ? 2'd2 : 2'd1;
      end else begin
        push.first = sec;
        push.cnt   = sec_v ? 2'd1 : 2'd0;
      end
      if (push.cnt == 2'd1) begin
        push.first.last_result = 1'b1;
      end
      if (push.cnt == 2'd2) begin
        push.second.last_result = 1'b1;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      bp_r    <= '0;
      acc_r   <= '0;
      cid_r   <= '0;
      rem_r   <= '0;
      hl_r    <= '0;
      hp_r    <= '0;
      rl_r    <= 17'd2;
      errl_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      bp_r    <= bp_nxt;
      acc_r   <= acc_nxt;
      cid_r   <= cid_nxt;
      rem_r   <= rem_nxt;
      hl_r    <= hl_nxt;
      hp_r    <= hp_nxt;
      rl_r    <= rl_nxt;
      errl_r  <= errl_nxt;
    end
  end

  // A latched error silences every byte until the end of stream.
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && errl_r) |-> (push.cnt == 2'd0))
    else $error("results produced while an error is latched");

  // An end of stream always leaves the parser in its reset state.
  a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && item.end_of_stream) |=>
      (phase_r == PH_HEADER && bp_r == 2'd0 && rl_r == 17'd2 && !errl_r))
    else $error("parser did not restart after end of stream");

  // The running length never passes the message limit.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rl_r >= 17'd2 && {1'b0, rl_r} <= MSG_MAX)
    else $error("running length out of range");

endmodule

@@ rtl/core/tlvp_out_fifo.sv @@
// Result queue of the TLV message parser: takes up to two results per cycle
// and hands out one per transfer. Depends on tlvp_pkg.
module tlvp_out_fifo import tlvp_pkg::*; #(
  parameter int DEPTH = TLVP_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  tlvp_push_t push,
  output logic       space_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM_MAX  = CW'(DEPTH - 2);
  localparam logic [CW-1:0] FULL      = CW'(DEPTH);

  out_item_t     mem [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_second;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] a);
    return (a == LAST_ADDR) ? '0 : a + AW'(1);
  endfunction

  // Two free entries let any byte's results in.
  assign space_ok  = (count_r <= ROOM_MAX);
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_r];
  assign pop       = out_valid && out_ready;

  // Pointer and fill count updates.
  always_comb begin
    wr_second = inc(wr_r);
    wr_nxt    = wr_r;
    if (push.cnt == 2'd1) begin
      wr_nxt = wr_second;
    end else if (push.cnt == 2'd2) begin
      wr_nxt = inc(wr_second);
    end
    rd_nxt    = pop ? inc(rd_r) : rd_r;
    count_nxt = count_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_second] <= push.second;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> space_ok)
    else $error("results pushed without room");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd0 && !pop) |=> $stable(count_r) && $stable(wr_r))
    else $error("queue changed without a push or pop");

endmodule

@@ dv/tb_tlv_message_parser_top.sv @@
// Self-checking testbench for tlv_message_parser_top: streams message bytes,
// predicts every parser event and compares the result channel field by field.
// Depends on tlvp_pkg and the parser RTL.
module tb_tlv_message_parser_top;
  import tlvp_pkg::*;

  localparam int BYTE_TARGET = 1800;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_TAIL  = 20;
  localparam int PRINT_LIMIT = 100;
  localparam out_item_t NO_EVENT = '0;

  // One row of the directed stimulus table.
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Predicted parser state.
  phase_t      ph;
  logic [1:0]  pos;
  logic [15:0] acc;
  logic [15:0] cur_id;
  logic [15:0] rem;
  logic [15:0] hdr_len;
  logic [15:0] hdr_proto;
  logic [16:0] run_len;
  bit          err_lat;

  out_item_t   events_due [$];
  logic [7:0]  msg_bytes [$];
  int          mismatches = 0;
  int          bytes_in = 0;
  int          stall_cycles = 0;
  bit          tx_calm = 0;
  bit          rx_calm = 0;

  wire in_fire  = in_valid && in_ready;
  wire out_fire = out_valid && out_ready;

  tlv_message_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic out_item_t mk_event(logic [2:0] ev, logic [15:0] hl, logic [15:0] hp,
                                         logic [15:0] id, logic [15:0] len, logic [7:0] vb,
                                         logic last, logic [1:0] err, logic lr);
    out_item_t r;
    r.event_res       = ev;
    r.header_length   = hl;
    r.header_protocol = hp;
    r.arg_id          = id;
    r.arg_length      = len;
    r.value_byte      = vb;
    r.last_of_arg     = last;
    r.error_code      = err;
    r.last_result     = lr;
    return r;
  endfunction

  // Bytes a value takes in its shortest varint form.
  function automatic int enc_size(logic [15:0] v);
    if (v <= 16'(SHORT_MAX)) return 1;
    if (v <= 16'd255) return 2;
    return 3;
  endfunction

  // Mostly short gaps, a few long ones, none at all in a calm stretch.
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic reset_parser();
    ph        = PH_HEADER;
    pos       = '0;
    acc       = '0;
    cur_id    = '0;
    rem       = '0;
    hdr_len   = '0;
    hdr_proto = '0;
    run_len   = 17'd2;
    err_lat   = 1'b0;
  endtask

  // Advance the predicted parser by one byte and collect the events it causes.
  task automatic parse_byte(input in_item_t it, output out_item_t evs [$]);
    logic [7:0]  b;
    logic [1:0]  err;
    logic        done;
    logic [15:0] v;
    int          total;
    out_item_t   tail;
    evs  = {};
    b    = it.data_byte;
    err  = ERR_NONE;
    done = 1'b0;
    v    = '0;
    if (!err_lat) begin
      case (ph)
        PH_HEADER: begin
          if (pos < 2'd2) hdr_len = {hdr_len[7:0], b};
          else hdr_proto = {hdr_proto[7:0], b};
          if (pos == 2'd3) begin
            ph  = PH_ID;
            pos = '0;
            evs.push_back(mk_event(EV_HEADER, hdr_len, hdr_proto, 0, 0, 0, 0, ERR_NONE, 0));
          end else begin
            pos = pos + 2'd1;
          end
        end
        PH_ID, PH_LEN: begin
          // Varint: short form, or a prefix announcing one or two more bytes.
          if (pos == 2'd0) begin
            if (b <= SHORT_MAX) begin
              done = 1'b1;
              v    = {8'h00, b};
            end else if (b == PREFIX_ONE) begin
              pos = 2'd1;
              acc = '0;
            end else if (b == PREFIX_TWO) begin
              pos = 2'd2;
              acc = '0;
            end else begin
              err = ERR_PREFIX;
            end
          end else begin
            acc = {acc[7:0], b};
            pos = pos - 2'd1;
            if (pos == 2'd0) begin
              done = 1'b1;
              v    = acc;
            end
          end
          if (done && ph == PH_ID) begin
            cur_id = v;
            ph     = PH_LEN;
          end else if (done) begin
            // An argument that pushes the message past its limit is refused.
            total = int'(run_len) + enc_size(cur_id) + enc_size(v) + int'(v);
            if (total > int'(MSG_MAX)) begin
              err = ERR_OVERFLOW;
            end else begin
              run_len = total[16:0];
              evs.push_back(mk_event(EV_ARG_START, hdr_len, hdr_proto, cur_id, v, 0, 0,
                                     ERR_NONE, 0));
              if (v == 16'd0) begin
                ph = PH_ID;
              end else begin
                rem = v;
                ph  = PH_VALUE;
              end
            end
          end
        end
        default: begin
          evs.push_back(mk_event(EV_VALUE, hdr_len, hdr_proto, cur_id, 0, b, rem == 16'd1,
                                 ERR_NONE, 0));
          rem = rem - 16'd1;
          if (rem == 16'd0) ph = PH_ID;
        end
      endcase
      if (err != ERR_NONE) begin
        evs.push_back(mk_event(EV_ERROR, hdr_len, hdr_proto, 0, 0, 0, 0, err, 0));
        err_lat = 1'b1;
      end
      // The end of the buffer either closes the message or cuts it short.
      if (it.end_of_stream && !err_lat) begin
        if (ph == PH_ID && pos == 2'd0)
          evs.push_back(mk_event(EV_MSG_END, hdr_len, hdr_proto, 0, 0, 0, 0, ERR_NONE, 0));
        else
          evs.push_back(mk_event(EV_ERROR, hdr_len, hdr_proto, 0, 0, 0, 0, ERR_TRUNCATED, 0));
      end
    end
    if (it.end_of_stream) reset_parser();
    if (evs.size() > 0) begin
      tail = evs.pop_back();
      tail.last_result = 1'b1;
      evs.push_back(tail);
    end
  endtask

  // Append a varint for v, picking any legal encoding at random.
  task automatic put_varint(logic [15:0] v);
    int form;
    if (v <= 16'(SHORT_MAX)) form = $urandom_range(0, 2);
    else if (v <= 16'd255) form = $urandom_range(1, 2);
    else form = 2;
    if (form == 0) begin
      msg_bytes.push_back(v[7:0]);
    end else if (form == 1) begin
      msg_bytes.push_back(PREFIX_ONE);
      msg_bytes.push_back(v[7:0]);
    end else begin
      msg_bytes.push_back(PREFIX_TWO);
      msg_bytes.push_back(v[15:8]);
      msg_bytes.push_back(v[7:0]);
    end
  endtask

  // Offer one byte after a random gap and hold it until the transfer.
  task automatic send_byte(in_item_t it);
    int g;
    g = pick_gap(tx_calm);
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    bytes_in++;
    if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
  endtask

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endtask

  // Compare each result transfer with the oldest pending event.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_fire) begin
      if (events_due.size() == 0) begin
        report("result with no event pending", 0, out_data.event_res);
      end else begin
        want = events_due.pop_front();
        if (out_data.event_res !== want.event_res)
          report("event_res", want.event_res, out_data.event_res);
        if (out_data.header_length !== want.header_length)
          report("header_length", want.header_length, out_data.header_length);
        if (out_data.header_protocol !== want.header_protocol)
          report("header_protocol", want.header_protocol, out_data.header_protocol);
        if (out_data.arg_id !== want.arg_id)
          report("arg_id", want.arg_id, out_data.arg_id);
        if (out_data.arg_length !== want.arg_length)
          report("arg_length", want.arg_length, out_data.arg_length);
        if (out_data.value_byte !== want.value_byte)
          report("value_byte", want.value_byte, out_data.value_byte);
        if (out_data.last_of_arg !== want.last_of_arg)
          report("last_of_arg", want.last_of_arg, out_data.last_of_arg);
        if (out_data.error_code !== want.error_code)
          report("error_code", want.error_code, out_data.error_code);
        if (out_data.last_result !== want.last_result)
          report("last_result", want.last_result, out_data.last_result);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: random stalls, and one long hold-off that backs the block up.
  initial begin
    int  g;
    bit  held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && bytes_in >= HOLD_AT) begin
        held = 1'b1;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end
      g = pick_gap(rx_calm);
      if (g > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
    end
  end

  // Byte side: directed table, then random messages, then drain and verdict.
  initial begin
    row_t       dir_tab [27];
    in_item_t   it;
    out_item_t  evs [$];
    int         n_args;
    int         len;
    int         r;
    int         cut;
    logic [15:0] id;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    reset_parser();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    dir_tab = '{
      // Header 0005/1234, zero-length argument with the largest short id,
      // then id 65535 with a two-byte value ending the buffer.
      '{'{8'h00, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'h05, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'h12, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'h34, 1'b0}, 1'b1,
        mk_event(EV_HEADER, 16'h0005, 16'h1234, 0, 0, 0, 0, ERR_NONE, 1)},
      '{'{8'h7F, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'h00, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'h82, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'hFF, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'hFF, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'h81, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'h02, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'h00, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'hFF, 1'b1}, 1'b0, NO_EVENT},
      // All-ones header, then a reserved varint prefix on the last byte.
      '{'{8'hFF, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'hFF, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'hFF, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'hFF, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'h80, 1'b1}, 1'b1,
        mk_event(EV_ERROR, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, ERR_PREFIX, 1)},
      // Buffer ends on the first header byte.
      '{'{8'h01, 1'b1}, 1'b1,
        mk_event(EV_ERROR, 16'h0001, 16'h0000, 0, 0, 0, 0, ERR_TRUNCATED, 1)},
      // Length 65535 overflows the message; the end of buffer is then ignored.
      '{'{8'h00, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'h00, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'h00, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'h00, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'h00, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'h82, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'hFF, 1'b0}, 1'b0, NO_EVENT},
      '{'{8'hFF, 1'b1}, 1'b1,
        mk_event(EV_ERROR, 16'h0000, 16'h0000, 0, 0, 0, 0, ERR_OVERFLOW, 1)}
    };

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].item);
      parse_byte(dir_tab[i].item, evs);
      if (dir_tab[i].typed) events_due.push_back(dir_tab[i].want);
      else events_due = {events_due, evs};
    end

    // Random messages: mostly well formed, some cut short, corrupted or noise.
    while (bytes_in < BYTE_TARGET) begin
      msg_bytes = {};
      repeat (4) msg_bytes.push_back(8'($urandom_range(0, 255)));
      n_args = $urandom_range(0, 4);
      for (int a = 0; a < n_args; a++) begin
        r = $urandom_range(0, 99);
        if (r < 60) id = 16'($urandom_range(0, 127));
        else if (r < 85) id = 16'($urandom_range(128, 255));
        else id = 16'($urandom_range(0, 65535));
        put_varint(id);
        r = $urandom_range(0, 99);
        if (r < 3) begin
          // Lengths this large always overflow the message.
          put_varint(16'($urandom_range(65530, 65535)));
          break;
        end
        if (r < 12) len = 0;
        else if (r < 80) len = $urandom_range(1, 6);
        else if (r < 95) len = $urandom_range(7, 40);
        else len = $urandom_range(120, 300);
        put_varint(16'(len));
        repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end
      r = $urandom_range(0, 99);
      if (r >= 70 && r < 82) begin
        cut = $urandom_range(1, msg_bytes.size());
        msg_bytes = msg_bytes[0:cut-1];
      end else if (r >= 82 && r < 94) begin
        msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r >= 94) begin
        msg_bytes = {};
        repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end
      foreach (msg_bytes[i]) begin
        it.data_byte     = msg_bytes[i];
        it.end_of_stream = (i == msg_bytes.size() - 1);
        send_byte(it);
        parse_byte(it, evs);
        events_due = {events_due, evs};
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (events_due.size() != 0) report("events left pending", 0, events_due.size());
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
